[rtl/core/trt_pkg.sv]
// Shared types and constants for the transaction recovery table.
package trt_pkg;

	localparam int unsigned TRT_TABLE_DEPTH  = 16;
	localparam int unsigned TRT_RESULT_LIMIT = 16;
	localparam int unsigned TRT_ID_W         = 32;
	localparam int unsigned TRT_TYPE_W       = 3;
	localparam int unsigned TRT_CMD_W        = 2;
	localparam int unsigned TRT_KIND_W       = 2;
	localparam int unsigned TRT_DATA_W       = 40;

	typedef enum logic [TRT_CMD_W-1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_ANALYSIS = 2'd1,
		CMD_REDO     = 2'd2,
		CMD_UNDO     = 2'd3
	} trt_cmd_t;

	typedef enum logic [TRT_TYPE_W-1:0] {
		LT_BEGIN  = 3'd0,
		LT_COMMIT = 3'd1,
		LT_ABORT  = 3'd2,
		LT_INSERT = 3'd3,
		LT_UPDATE = 3'd4,
		LT_DELETE = 3'd5,
		LT_OTHER  = 3'd6
	} trt_log_t;

	typedef enum logic [TRT_KIND_W-1:0] {
		KIND_OVERFLOW = 2'd0,
		KIND_REDO     = 2'd1,
		KIND_UNDO     = 2'd2
	} trt_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DECIDE,
		ST_FINAL
	} trt_state_t;

	typedef struct packed {
		logic [TRT_KIND_W-1:0] kind;
		logic [TRT_ID_W-1:0]   txn_id;
		logic [TRT_TYPE_W-1:0] log_type;
		logic                  last;
	} trt_result_t;

endpackage

[rtl/core/trt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module trt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/trt_out_reg.sv]
// Output register for result transfers on the master stream.
module trt_out_reg import trt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  trt_result_t           res,
	output logic                  free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TRT_DATA_W-1:0] m_axis_tdata,
	output logic [TRT_KIND_W-1:0] m_axis_tuser,
	output logic                  m_axis_tlast
);

	logic        valid_q;
	trt_result_t res_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && free) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = TRT_DATA_W'({res_q.log_type, res_q.txn_id});
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last;

endmodule

[rtl/core/trt_engine.sv]
// Table sequencer: sweeps the ID memory for match, free slot and undo ordering.
module trt_engine import trt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TRT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TRT_CMD_W-1:0]  in_cmd,
	input  logic [TRT_ID_W-1:0]   in_id,
	input  logic [TRT_TYPE_W-1:0] in_type,
	input  logic                  out_free,
	output logic                  push,
	output trt_result_t           res
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TRT_RESULT_LIMIT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(TRT_RESULT_LIMIT);

	trt_state_t state_q, state_d;

	logic [TRT_CMD_W-1:0]  cmd_q;
	logic [TRT_ID_W-1:0]   id_q;
	logic [TRT_TYPE_W-1:0] type_q;

	logic [IDX_W-1:0]       ptr_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TABLE_DEPTH-1:0] committed_q;
	logic [TABLE_DEPTH-1:0] active_q;

	logic                match_found_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                best_found_q;
	logic [TRT_ID_W-1:0] best_id_q;
	logic                have_pend_q;
	logic [TRT_ID_W-1:0] pend_id_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [TRT_ID_W-1:0] rd_data;
	logic                ram_we;

	logic accept, accept_scan, start_scan, load_pend, tbl_upd;
	logic in_use_s1, id_hit, cand;
	logic slot_ok, overflow, redo_hit, is_undo, last_scan;
	logic [IDX_W-1:0] slot;

	trt_ram #(
		.WIDTH(TRT_ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_id_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(id_q),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign in_use_s1 = committed_q[idx_s1] | active_q[idx_s1];
	assign id_hit    = in_use_s1 && (rd_data == id_q);
	// smallest active ID strictly above the one already taken
	assign cand      = active_q[idx_s1] && (!have_pend_q || rd_data > pend_id_q)
		&& (!best_found_q || rd_data < best_id_q);

	assign is_undo   = (cmd_q == CMD_UNDO);
	assign slot_ok   = match_found_q || free_found_q;
	assign slot      = match_found_q ? match_idx_q : free_idx_q;
	assign overflow  = (cmd_q == CMD_ANALYSIS) && (type_q != LT_ABORT) && !slot_ok;
	assign redo_hit  = (cmd_q == CMD_REDO) && match_found_q && committed_q[match_idx_q];
	assign last_scan = (cnt_q + CNT_W'(1)) == LIMIT;

	always_comb begin
		case (in_cmd)
			CMD_ANALYSIS: accept_scan = (in_type <= LT_ABORT);
			CMD_REDO:     accept_scan = (in_type >= LT_INSERT) && (in_type <= LT_DELETE);
			CMD_UNDO:     accept_scan = 1'b1;
			default:      accept_scan = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && accept_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ptr_q == LAST_IDX) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (is_undo) begin
					if (!have_pend_q || out_free) begin
						if (!best_found_q) begin
							state_d = ST_IDLE;
						end else if (last_scan) begin
							state_d = ST_FINAL;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end else if (!(overflow || redo_hit) || out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		push          = 1'b0;
		start_scan    = 1'b0;
		load_pend     = 1'b0;
		tbl_upd       = 1'b0;
		res.kind      = KIND_UNDO;
		res.txn_id    = pend_id_q;
		res.log_type  = LT_ABORT;
		res.last      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				start_scan    = accept && accept_scan;
			end
			ST_DECIDE: begin
				if (is_undo) begin
					push       = have_pend_q && out_free;
					res.last   = !best_found_q;
					load_pend  = (!have_pend_q || out_free) && best_found_q;
					start_scan = load_pend && !last_scan;
				end else begin
					push         = (overflow || redo_hit) && out_free;
					res.kind     = overflow ? KIND_OVERFLOW : KIND_REDO;
					res.txn_id   = id_q;
					res.log_type = type_q;
					tbl_upd      = (cmd_q == CMD_ANALYSIS) && (!overflow || out_free);
				end
			end
			ST_FINAL: begin
				push = out_free;
			end
			default: begin
			end
		endcase
	end

	assign ram_we = tbl_upd && !match_found_q && free_found_q && (type_q != LT_ABORT);

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= in_id;
			type_q <= in_type;
		end
		idx_s1 <= ptr_q;
		if (vld_s1 && id_hit && !match_found_q) begin
			match_idx_q <= idx_s1;
		end
		if (vld_s1 && !in_use_s1 && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (vld_s1 && cand) begin
			best_id_q <= rd_data;
		end
		if (load_pend) begin
			pend_id_q <= best_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= CMD_CLEAR;
			ptr_q         <= '0;
			vld_s1        <= 1'b0;
			committed_q   <= '0;
			active_q      <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
			have_pend_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);
			if (accept) begin
				cmd_q <= in_cmd;
				if (in_cmd == CMD_CLEAR) begin
					committed_q <= '0;
					active_q    <= '0;
				end
				if (in_cmd == CMD_UNDO) begin
					have_pend_q <= 1'b0;
					cnt_q       <= '0;
				end
			end
			if (start_scan) begin
				ptr_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				best_found_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (vld_s1) begin
				if (id_hit) begin
					match_found_q <= 1'b1;
				end
				if (!in_use_s1) begin
					free_found_q <= 1'b1;
				end
				if (cand) begin
					best_found_q <= 1'b1;
				end
			end
			if (load_pend) begin
				have_pend_q <= 1'b1;
				cnt_q       <= cnt_q + CNT_W'(1);
			end
			if (tbl_upd) begin
				case (type_q)
					LT_BEGIN: begin
						if (match_found_q) begin
							active_q[match_idx_q] <= 1'b1;
						end else if (free_found_q) begin
							committed_q[free_idx_q] <= 1'b0;
							active_q[free_idx_q]    <= 1'b1;
						end
					end
					LT_COMMIT: begin
						if (slot_ok) begin
							committed_q[slot] <= 1'b1;
							active_q[slot]    <= 1'b0;
						end
					end
					LT_ABORT: begin
						if (match_found_q) begin
							active_q[match_idx_q] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[rtl/core/txn_log_recovery_table_top.sv]
// Transaction recovery table: analysis, redo filter and undo abort listing.
//
// Usage:
//  Slave stream carries log records and commands: tuser holds the command
//  (clear, analysis, redo, undo), tdata holds txn_id and log_type.
//  Master stream carries results: tuser holds the kind (overflow, redo kept,
//  undo abort), tdata holds txn_id and log_type, tlast marks the final result
//  of one input transfer; on an undo listing it marks the log flush.
//  Clear, and analysis or redo records of a type that is ignored, finish
//  on acceptance. Analysis and redo records take one sweep over the single
//  read port of the ID memory, a tail step to finish the last compare and a
//  decide step to update the table. Undo lists the active IDs one sweep per
//  ID, in ascending order, and ends with a closing sweep that finds none; a
//  full listing of 16 IDs skips the closing sweep.
//  A result sits in an output register, so the block takes the next transfer
//  while a result waits; during undo the sweep holds, and an analysis or
//  redo result waits, until the register is free. Reset empties the table
//  at once: the committed and active flags are flip-flops, the ID memory
//  needs no clearing.
module txn_log_recovery_table_top import trt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TRT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TRT_DATA_W-1:0] s_axis_tdata,  // txn_id[31:0], log_type[34:32], zero pad
	input  logic [TRT_CMD_W-1:0]  s_axis_tuser,  // command[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TRT_DATA_W-1:0] m_axis_tdata,  // out_txn_id[31:0], out_log_type[34:32], zero pad
	output logic [TRT_KIND_W-1:0] m_axis_tuser,  // kind[1:0]
	output logic                  m_axis_tlast
);

	logic        out_free;
	logic        push;
	trt_result_t res;

	trt_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.in_cmd       (s_axis_tuser),
		.in_id        (s_axis_tdata[TRT_ID_W-1:0]),
		.in_type      (s_axis_tdata[TRT_ID_W +: TRT_TYPE_W]),
		.out_free     (out_free),
		.push         (push),
		.res          (res)
	);

	trt_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.res          (res),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

[rtl/core/trt_chk.sv]
// Port-level checks on the result stream, bound to the top level.
module trt_chk import trt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [TRT_DATA_W-1:0] m_axis_tdata,
	input logic [TRT_KIND_W-1:0] m_axis_tuser,
	input logic                  m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("unused result kind");

	a_undo_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_UNDO |-> m_axis_tdata[34:32] == LT_ABORT)
		else $error("undo result without abort type");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_UNDO |-> m_axis_tlast)
		else $error("single result without tlast");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[TRT_DATA_W-1:35] == '0)
		else $error("tdata padding not zero");

endmodule

bind txn_log_recovery_table_top trt_chk u_chk (.*);
